// ===== hw/rtl/mide_pkg.sv =====
package mide_pkg;

  // Register file geometry.
  localparam int unsigned RegCount = 32;
  localparam int unsigned RegAddrW = $clog2(RegCount);

  // Special words and fixed register numbers.
  localparam logic [31:0]         SYSCALL_WORD = 32'h0000_000C;
  localparam logic [RegAddrW-1:0] REG_V0       = RegAddrW'(2);
  localparam logic [RegAddrW-1:0] REG_A0       = RegAddrW'(4);
  localparam logic [RegAddrW-1:0] REG_LINK     = RegAddrW'(31);

  // Primary opcodes.
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_LUI     = 6'h0F;

  // Function codes of the special opcode.
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  // Redirect kinds.
  typedef enum logic [1:0] {
    REDIR_NONE  = 2'd0,
    REDIR_LABEL = 2'd1,
    REDIR_REG   = 2'd2
  } redir_e;

  // One result word.
  typedef struct packed {
    logic [31:0]         instruction_address;
    logic                write_enable;
    logic [RegAddrW-1:0] write_register;
    logic [31:0]         write_value;
    redir_e              redirect_kind;
    logic [25:0]         redirect_value;
    logic                is_syscall;
    logic [31:0]         syscall_code;
    logic [31:0]         syscall_argument;
    logic                unknown_instruction;
  } result_t;

  // Register file write port.
  typedef struct packed {
    logic                en;
    logic [RegAddrW-1:0] addr;
    logic [31:0]         data;
  } rf_wr_t;

endpackage

// ===== hw/rtl/mide_if.sv =====
interface mide_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

interface mide_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_address;
  logic        write_enable;
  logic [4:0]  write_register;
  logic [31:0] write_value;
  logic [1:0]  redirect_kind;
  logic [25:0] redirect_value;
  logic        is_syscall;
  logic [31:0] syscall_code;
  logic [31:0] syscall_argument;
  logic        unknown_instruction;

  modport source (
    output valid, output instruction_address, output write_enable,
    output write_register, output write_value, output redirect_kind,
    output redirect_value, output is_syscall, output syscall_code,
    output syscall_argument, output unknown_instruction, input ready
  );
  modport sink (
    input valid, input instruction_address, input write_enable,
    input write_register, input write_value, input redirect_kind,
    input redirect_value, input is_syscall, input syscall_code,
    input syscall_argument, input unknown_instruction, output ready
  );
endinterface

// ===== hw/rtl/mips_integer_decode_execute.sv =====
// Stage one holds an accepted word and its reads; the output word is then registered.
// Throughput: one instruction per cycle unless the output stalls; the register file
// takes one write and two reads each cycle; a write is forwarded to a same-cycle read.
// Reset: the address counter clears to zero and every register reads as zero until
// written, through per-register written flags; no clearing pass is needed.
module mips_integer_decode_execute (
  input  logic           clk_i,
  input  logic           rst_ni,
  mide_instr_if.sink     in_i,
  mide_result_if.source  out_o
);
  import mide_pkg::*;

  logic                s1_valid_q;
  logic [31:0]         s1_word_q;
  logic [31:0]         s1_pc_q;
  logic [31:0]         pc_q;
  logic                out_valid_q;
  result_t             out_q;
  result_t             res;
  logic                s1_adv, in_ready, accept, in_sys;
  logic [RegAddrW-1:0] ra_addr, rb_addr;
  logic [31:0]         a_data, b_data;
  rf_wr_t              rf_wr;

  // Handshake: stage one moves on when the output register is free or drains.
  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || s1_adv;
  assign accept   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // Read addresses; a syscall reads the code and argument registers.
  assign in_sys  = (in_i.instruction == SYSCALL_WORD);
  assign ra_addr = in_sys ? REG_V0 : in_i.instruction[25:21];
  assign rb_addr = in_sys ? REG_A0 : in_i.instruction[20:16];

  // Writeback as the result leaves stage one.
  assign rf_wr.en   = s1_adv && res.write_enable;
  assign rf_wr.addr = res.write_register;
  assign rf_wr.data = res.write_value;

  mide_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .ra_addr_i (ra_addr),
    .rb_addr_i (rb_addr),
    .ra_data_o (a_data),
    .rb_data_o (b_data),
    .wr_i      (rf_wr)
  );

  mide_execute u_execute (
    .word_i (s1_word_q),
    .pc_i   (s1_pc_q),
    .a_i    (a_data),
    .b_i    (b_data),
    .res_o  (res)
  );

  // Stage one payload and output word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_word_q <= in_i.instruction;
      s1_pc_q   <= pc_q;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pc_q <= pc_q + 32'd4;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output port.
  assign out_o.valid               = out_valid_q;
  assign out_o.instruction_address = out_q.instruction_address;
  assign out_o.write_enable        = out_q.write_enable;
  assign out_o.write_register      = out_q.write_register;
  assign out_o.write_value         = out_q.write_value;
  assign out_o.redirect_kind       = out_q.redirect_kind;
  assign out_o.redirect_value      = out_q.redirect_value;
  assign out_o.is_syscall          = out_q.is_syscall;
  assign out_o.syscall_code        = out_q.syscall_code;
  assign out_o.syscall_argument    = out_q.syscall_argument;
  assign out_o.unknown_instruction = out_q.unknown_instruction;

endmodule

// ===== hw/rtl/mide_regfile.sv =====
module mide_regfile (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [mide_pkg::RegAddrW-1:0]  ra_addr_i,
  input  logic [mide_pkg::RegAddrW-1:0]  rb_addr_i,
  output logic [31:0]                    ra_data_o,
  output logic [31:0]                    rb_data_o,
  input  mide_pkg::rf_wr_t               wr_i
);
  import mide_pkg::*;

  logic [31:0]         mem_q [RegCount];
  logic [RegCount-1:0] vld_q;
  logic [31:0]         ra_q, rb_q, byp_q;
  logic                ra_vld_q, rb_vld_q, ra_hit_q, rb_hit_q;

  // Storage and registered read ports; a read in the write cycle sees old data.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      ra_q  <= mem_q[ra_addr_i];
      rb_q  <= mem_q[rb_addr_i];
      byp_q <= wr_i.data;
    end
  end

  // Written flags stand in for the zero reset; hit flags forward a same-cycle write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      ra_vld_q <= 1'b0;
      rb_vld_q <= 1'b0;
      ra_hit_q <= 1'b0;
      rb_hit_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        ra_vld_q <= vld_q[ra_addr_i];
        rb_vld_q <= vld_q[rb_addr_i];
        ra_hit_q <= wr_i.en && (wr_i.addr == ra_addr_i);
        rb_hit_q <= wr_i.en && (wr_i.addr == rb_addr_i);
      end
    end
  end

  // Read data selection.
  assign ra_data_o = ra_hit_q ? byp_q : (ra_vld_q ? ra_q : '0);
  assign rb_data_o = rb_hit_q ? byp_q : (rb_vld_q ? rb_q : '0);

endmodule

// ===== hw/rtl/mide_execute.sv =====
module mide_execute (
  input  logic [31:0]        word_i,
  input  logic [31:0]        pc_i,
  input  logic [31:0]        a_i,
  input  logic [31:0]        b_i,
  output mide_pkg::result_t  res_o
);
  import mide_pkg::*;

  logic [5:0]          op, fn;
  logic [4:0]          sh;
  logic [15:0]         imm;
  logic [31:0]         simm;
  logic [31:0]         pc_next;
  logic                wr;
  logic [RegAddrW-1:0] dest;
  logic [31:0]         val;

  // Field split.
  assign op      = word_i[31:26];
  assign sh      = word_i[10:6];
  assign fn      = word_i[5:0];
  assign imm     = word_i[15:0];
  assign simm    = {{16{imm[15]}}, imm};
  assign pc_next = pc_i + 32'd4;

  // Decode and execute.
  always_comb begin
    res_o                     = '0;
    res_o.instruction_address = pc_i;
    res_o.redirect_kind       = REDIR_NONE;
    wr                        = 1'b0;
    dest                      = '0;
    val                       = '0;
    if (word_i == SYSCALL_WORD) begin
      res_o.is_syscall       = 1'b1;
      res_o.syscall_code     = a_i;
      res_o.syscall_argument = b_i;
    end else if (op == OP_SPECIAL) begin
      wr   = 1'b1;
      dest = word_i[15:11];
      unique case (fn) inside
        FN_ADD, FN_ADDU: val = a_i + b_i;
        FN_SUB, FN_SUBU: val = a_i - b_i;
        FN_AND:          val = a_i & b_i;
        FN_OR:           val = a_i | b_i;
        FN_NOR:          val = ~(a_i | b_i);
        FN_SLT:          val = {31'd0, $signed(a_i) < $signed(b_i)};
        FN_SLTU:         val = {31'd0, a_i < b_i};
        FN_SLL:          val = b_i << sh;
        FN_SRL:          val = b_i >> sh;
        FN_JR: begin
          wr                   = 1'b0;
          res_o.redirect_kind  = REDIR_REG;
          res_o.redirect_value = a_i[25:0];
        end
        default: begin
          wr                        = 1'b0;
          res_o.unknown_instruction = 1'b1;
        end
      endcase
    end else begin
      wr   = 1'b1;
      dest = word_i[20:16];
      unique case (op) inside
        OP_ADDI, OP_ADDIU: val = a_i + simm;
        OP_SLTI:           val = {31'd0, $signed(a_i) < $signed(simm)};
        OP_SLTIU:          val = {31'd0, a_i < simm};
        OP_ANDI:           val = a_i & {16'd0, imm};
        OP_ORI:            val = a_i | {16'd0, imm};
        OP_LUI:            val = {imm, 16'd0};
        OP_BEQ, OP_BNE: begin
          wr = 1'b0;
          if ((op == OP_BEQ) == (a_i == b_i)) begin
            res_o.redirect_kind  = REDIR_LABEL;
            res_o.redirect_value = {10'd0, imm};
          end
        end
        OP_J: begin
          wr                   = 1'b0;
          res_o.redirect_kind  = REDIR_LABEL;
          res_o.redirect_value = word_i[25:0];
        end
        OP_JAL: begin
          dest                 = REG_LINK;
          val                  = pc_next;
          res_o.redirect_kind  = REDIR_LABEL;
          res_o.redirect_value = word_i[25:0];
        end
        default: begin
          wr                        = 1'b0;
          res_o.unknown_instruction = 1'b1;
        end
      endcase
    end
    // Register zero is never written and a missing write reports zeros.
    if (wr && (dest != '0)) begin
      res_o.write_enable   = 1'b1;
      res_o.write_register = dest;
      res_o.write_value    = val;
    end
  end

endmodule

// ===== hw/rtl/mide_checker.sv =====
module mide_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] instruction_address_i,
  input logic        write_enable_i,
  input logic [4:0]  write_register_i,
  input logic [31:0] write_value_i,
  input logic [1:0]  redirect_kind_i,
  input logic [25:0] redirect_value_i,
  input logic        is_syscall_i,
  input logic [31:0] syscall_code_i,
  input logic [31:0] syscall_argument_i,
  input logic        unknown_instruction_i
);
  import mide_pkg::*;

  logic [31:0] exp_addr_q;

  // Address the next delivered word must carry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_addr_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      exp_addr_q <= exp_addr_q + 32'd4;
    end
  end

  // A stalled word keeps its address and write value.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(instruction_address_i) && $stable(write_value_i))
    else $error("stalled result word changed");

  // Words come out in order, four bytes apart.
  a_addr_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> instruction_address_i == exp_addr_q)
    else $error("instruction address out of sequence");

  // A write names a nonzero register; no write shows zeros.
  a_write_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (write_enable_i ? (write_register_i != '0)
                     : (write_register_i == '0 && write_value_i == '0)))
    else $error("inconsistent writeback fields");

  // An unknown word neither writes, redirects nor calls.
  a_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && unknown_instruction_i |->
      !write_enable_i && redirect_kind_i == REDIR_NONE && !is_syscall_i)
    else $error("unknown instruction had an effect");

  // Idle redirect and syscall fields read zero.
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (redirect_kind_i != REDIR_NONE || redirect_value_i == '0) &&
                    (is_syscall_i || (syscall_code_i == '0 && syscall_argument_i == '0)))
    else $error("nonzero redirect or syscall field");

endmodule

bind mips_integer_decode_execute mide_checker u_mide_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .out_valid_i           (out_o.valid),
  .out_ready_i           (out_o.ready),
  .instruction_address_i (out_o.instruction_address),
  .write_enable_i        (out_o.write_enable),
  .write_register_i      (out_o.write_register),
  .write_value_i         (out_o.write_value),
  .redirect_kind_i       (out_o.redirect_kind),
  .redirect_value_i      (out_o.redirect_value),
  .is_syscall_i          (out_o.is_syscall),
  .syscall_code_i        (out_o.syscall_code),
  .syscall_argument_i    (out_o.syscall_argument),
  .unknown_instruction_i (out_o.unknown_instruction)
);
